### design/binary_gcd_macros.svh
// ----------------------------------------------------------------------------
// Binary GCD assertion macros
// Shared concurrent assertion forms for the binary GCD block.
// ----------------------------------------------------------------------------
`ifndef BINARY_GCD_MACROS_SVH
`define BINARY_GCD_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BGCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define BGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bgcd_pkg.sv
// ----------------------------------------------------------------------------
// Binary GCD package
// Widths, command and status types shared by controller and datapath.
// ----------------------------------------------------------------------------
package bgcd_pkg;

    // Datapath width; operands are taken modulo 2^WIDTH
    localparam int WIDTH     = 32;
    localparam int KW        = $clog2(WIDTH);
    localparam int OPND_W    = 32;
    localparam int RES_W     = 32;
    localparam int IN_DATA_W = 2 * OPND_W;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture operands
        logic step;   // one shift or subtract step
        logic emit;   // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic equal;  // reduction finished
    } t_dp_stat;

endpackage

### design/bgcd_dp.sv
// ----------------------------------------------------------------------------
// Binary GCD datapath
// Operand registers, common power-of-two counter, shift/subtract step and
// result register.
// ----------------------------------------------------------------------------
module bgcd_dp (
    input  logic                      i_clk,
    input  bgcd_pkg::t_dp_cmd         i_cmd,
    input  logic [bgcd_pkg::OPND_W-1:0] i_first,
    input  logic [bgcd_pkg::OPND_W-1:0] i_second,
    output bgcd_pkg::t_dp_stat        o_stat,
    output logic [bgcd_pkg::RES_W-1:0]  o_divisor
);
    import bgcd_pkg::*;

    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_b, n_b;
    logic [KW-1:0]    r_k, n_k;
    logic [RES_W-1:0] r_res;
    logic [WIDTH-1:0] w_first, w_second;
    logic             w_a_even, w_b_even;

    assign w_first  = WIDTH'(i_first);
    assign w_second = WIDTH'(i_second);
    assign w_a_even = ~r_a[0];
    assign w_b_even = ~r_b[0];

    // Load operands or advance one reduction step
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (i_cmd.load) begin
            n_k = '0;
            // a zero operand finishes at once with the other one
            if (w_first == '0) begin
                n_a = w_second;
                n_b = w_second;
            end else if (w_second == '0) begin
                n_a = w_first;
                n_b = w_first;
            end else begin
                n_a = w_first;
                n_b = w_second;
            end
        end else if (i_cmd.step) begin
            if (w_a_even && w_b_even) begin
                // strip a common factor of two
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + KW'(1);
            end else begin
                if (w_a_even) begin
                    n_a = r_a >> 1;
                end
                if (w_b_even) begin
                    n_b = r_b >> 1;
                end
                // both odd: subtract smaller from larger
                if (!w_a_even && !w_b_even) begin
                    if (r_a > r_b) begin
                        n_a = r_a - r_b;
                    end else begin
                        n_b = r_b - r_a;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        // restore the common power of two
        if (i_cmd.emit) begin
            r_res <= RES_W'(r_a << r_k);
        end
    end

    assign o_stat.equal = (r_a == r_b);
    assign o_divisor    = r_res;

endmodule

### design/bgcd_ctrl.sv
// ----------------------------------------------------------------------------
// Binary GCD controller
// Sequences load, reduction steps and result hand-off; owns the output
// valid flag.
// ----------------------------------------------------------------------------
`include "binary_gcd_macros.svh"

module bgcd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bgcd_pkg::t_dp_cmd  o_cmd,
    input  bgcd_pkg::t_dp_stat i_stat
);
    import bgcd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    // Result register can take a new value if empty or drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // Derive datapath commands from state
    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step = (r_state == S_RUN) && !i_stat.equal;
        o_cmd.emit = (r_state == S_RUN) && i_stat.equal && w_out_free;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_cmd.emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `BGCD_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, o_cmd.load, r_state == S_RUN, "accepted transfer did not start a run")
    `BGCD_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, o_cmd.emit, r_out_valid, "emitted result not presented")
    `BGCD_ASSERT_IMP(a_step_not_done, i_clk, i_rst_n, o_cmd.step, !i_stat.equal && !o_cmd.emit, "step issued after reduction finished")

endmodule

### design/binary_gcd.sv
// The datapath takes one shift or subtract step per cycle while a reduction runs;
// a new pair is taken only in the idle state, also while the previous result still
// waits, and a finished reduction holds until the output drains.
// Reset: synchronous active-low i_rst_n clears controller state and the
// output valid flag; no memory clearing pass.
// ----------------------------------------------------------------------------
// Binary GCD top level
// Greatest common divisor of two unsigned operands by the binary method.
// ----------------------------------------------------------------------------
module binary_gcd (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [31:0] first_operand, [63:32] second_operand
    input  logic [bgcd_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] divisor
    output logic [bgcd_pkg::RES_W-1:0]     o_m_axis_tdata
);
    import bgcd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    bgcd_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_first   (i_s_axis_tdata[OPND_W-1:0]),
        .i_second  (i_s_axis_tdata[IN_DATA_W-1:OPND_W]),
        .o_stat    (w_stat),
        .o_divisor (o_m_axis_tdata)
    );

endmodule
